FILE: design/ir_pulse_frame_decoder_defines.svh
// ----------------------------------------------------------------------------
// IR pulse frame decoder assertion macros
// Concurrent assertion helpers. They compile to nothing when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef IR_PULSE_FRAME_DECODER_DEFINES_SVH
`define IR_PULSE_FRAME_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define IRPFD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");
// Next-cycle implication, disabled while reset is asserted.
`define IRPFD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define IRPFD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define IRPFD_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: design/irpfd_pkg.sv
// ----------------------------------------------------------------------------
// IR pulse frame decoder package
// Shared widths, register indexes, reset values and types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package irpfd_pkg;

	localparam int TICK_W    = 8;
	localparam int FRAME_W   = 32;
	localparam int CNT_W     = $clog2(FRAME_W);
	localparam int REG_IDX_W = 3;

	localparam logic [TICK_W-1:0] BYTE_ALL_ONES = 8'hff;

	// Configuration register indexes.
	localparam logic [REG_IDX_W-1:0] REG_START_MIN = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_START_MAX = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_ZERO_MIN  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_ZERO_MAX  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_ONE_MIN   = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_ONE_MAX   = 3'd5;

	// Reset values of the window bounds.
	localparam logic [TICK_W-1:0] RST_START_MIN = 8'd90;
	localparam logic [TICK_W-1:0] RST_START_MAX = 8'd105;
	localparam logic [TICK_W-1:0] RST_ZERO_MIN  = 8'd5;
	localparam logic [TICK_W-1:0] RST_ZERO_MAX  = 8'd11;
	localparam logic [TICK_W-1:0] RST_ONE_MIN   = 8'd13;
	localparam logic [TICK_W-1:0] RST_ONE_MAX   = 8'd19;

	// Exclusive window bounds for all three interval classes.
	typedef struct packed {
		logic [TICK_W-1:0] start_min;
		logic [TICK_W-1:0] start_max;
		logic [TICK_W-1:0] zero_min;
		logic [TICK_W-1:0] zero_max;
		logic [TICK_W-1:0] one_min;
		logic [TICK_W-1:0] one_max;
	} windows_t;

	// Classification of one interval.
	typedef struct packed {
		logic is_start;
		logic bit_val;
		logic is_bad;
	} interval_class_t;

endpackage

`default_nettype wire

FILE: design/irpfd_classify.sv
// ----------------------------------------------------------------------------
// IR pulse frame decoder interval classifier
// Sorts one interval into start, zero bit, one bit or bad bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module irpfd_classify
	import irpfd_pkg::*;
(
	input  wire logic [TICK_W-1:0] ticks,
	input  wire windows_t          windows,
	output interval_class_t        cls
);

	logic in_start;
	logic in_zero;
	logic in_one;

	// Every window is open at both ends.
	assign in_start = (ticks > windows.start_min) && (ticks < windows.start_max);
	assign in_zero  = (ticks > windows.zero_min)  && (ticks < windows.zero_max);
	assign in_one   = (ticks > windows.one_min)   && (ticks < windows.one_max);

	// The zero window wins over the one window; the decoder gives a start priority.
	always_comb begin
		cls.is_start = in_start;
		cls.bit_val  = !in_zero && in_one;
		cls.is_bad   = !in_zero && !in_one;
	end

endmodule

`default_nettype wire

FILE: design/ir_pulse_frame_decoder.sv
// ----------------------------------------------------------------------------
// IR pulse frame decoder
// Decodes 32-bit remote-control frames from falling-edge intervals.
// ----------------------------------------------------------------------------
// Each input beat carries one falling-edge interval, measured in ticks. Beats
// pass through an input register and are decoded from it into a result
// register, so the block takes one beat per clock cycle when the output side
// keeps up; the input register is held only while a finished result waits
// to be taken. A result beat (device high, device low, key code) appears at
// the edge at which the thirty-second bit of a frame leaves the input
// register, provided no bit fell outside its windows and the command byte ORed
// with its inverse byte gives all ones. Window bounds are exclusive and should
// be written only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

`include "ir_pulse_frame_decoder_defines.svh"

module ir_pulse_frame_decoder
	import irpfd_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// Interval input channel.
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [TICK_W-1:0]    interval_ticks,
	// Result channel.
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [TICK_W-1:0]         device_high,
	output logic [TICK_W-1:0]         device_low,
	output logic [TICK_W-1:0]         key_code,
	// Configuration write port.
	input  wire logic                 cfg_we,
	input  wire logic [REG_IDX_W-1:0] cfg_index,
	input  wire logic [TICK_W-1:0]    cfg_data
);

	windows_t            windows_q;
	logic                valid_s1;
	logic [TICK_W-1:0]   ticks_s1;
	logic [CNT_W-1:0]    bits_q;
	logic [FRAME_W-1:0]  shift_q;
	logic                bad_q;
	logic                out_valid_q;
	logic [TICK_W-1:0]   dev_high_q;
	logic [TICK_W-1:0]   dev_low_q;
	logic [TICK_W-1:0]   key_q;

	interval_class_t     cls;
	logic                advance;
	logic [FRAME_W-1:0]  shift_next;
	logic                bad_next;
	logic                frame_end;
	logic                cmd_ok;
	logic                emit;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			windows_q.start_min <= RST_START_MIN;
			windows_q.start_max <= RST_START_MAX;
			windows_q.zero_min  <= RST_ZERO_MIN;
			windows_q.zero_max  <= RST_ZERO_MAX;
			windows_q.one_min   <= RST_ONE_MIN;
			windows_q.one_max   <= RST_ONE_MAX;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_START_MIN: windows_q.start_min <= cfg_data;
				REG_START_MAX: windows_q.start_max <= cfg_data;
				REG_ZERO_MIN:  windows_q.zero_min  <= cfg_data;
				REG_ZERO_MAX:  windows_q.zero_max  <= cfg_data;
				REG_ONE_MIN:   windows_q.one_min   <= cfg_data;
				REG_ONE_MAX:   windows_q.one_max   <= cfg_data;
				default: ;
			endcase
		end
	end

	// The held beat moves on whenever the result register is free or drains.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ticks_s1 <= interval_ticks;
		end
	end

	irpfd_classify u_classify (
		.ticks   (ticks_s1),
		.windows (windows_q),
		.cls     (cls)
	);

	// Next frame contents and the end-of-frame checks.
	assign shift_next = {cls.bit_val, shift_q[FRAME_W-1:1]};
	assign bad_next   = bad_q || cls.is_bad;
	assign frame_end  = (bits_q == {CNT_W{1'b1}});
	assign cmd_ok     = ((shift_next[23:16] | shift_next[31:24]) == BYTE_ALL_ONES);
	assign emit       = advance && !cls.is_start && frame_end && !bad_next && cmd_ok;

	// Frame state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q  <= '0;
			shift_q <= '0;
			bad_q   <= 1'b0;
		end else if (advance) begin
			if (cls.is_start) begin
				bits_q <= '0;
				bad_q  <= 1'b0;
			end else begin
				shift_q <= shift_next;
				bits_q  <= bits_q + 1'b1;
				bad_q   <= bad_next && !frame_end;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			dev_high_q <= shift_next[7:0];
			dev_low_q  <= shift_next[15:8];
			key_q      <= shift_next[23:16];
		end
	end

	assign out_valid   = out_valid_q;
	assign device_high = dev_high_q;
	assign device_low  = dev_low_q;
	assign key_code    = key_q;

	// A fresh result always closes a frame cleanly.
	`IRPFD_ASSERT_IMP(a_result_closes_frame, clk, arst_n, $rose(out_valid_q), (bits_q == '0) && !bad_q)
	// The error mark lives only inside a partly received frame.
	`IRPFD_ASSERT_IMP(a_bad_mid_frame, clk, arst_n, bad_q, bits_q != '0)
	// Input stalls only behind a held beat and a blocked result.
	`IRPFD_ASSERT_IMP(a_stall_cause, clk, arst_n, !in_ready, valid_s1 && out_valid_q && !out_ready)

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR pulse frame decoder testbench
// Drives falling-edge intervals into the decoder and checks every decoded
// frame. A scoreboard predicts the frames from its own copy of the window
// registers and the frame state. Stimulus is a short run of hand-picked
// intervals, then mostly well-formed frames with random content, mixed with
// broken frames and noise. Both sides idle at random, and the window settings
// change between phases.
// ----------------------------------------------------------------------------

module tb_top;
	import irpfd_pkg::*;

	localparam int CLK_PERIOD     = 20;
	localparam int RESET_CYCLES   = 12;
	localparam int DRAIN_TAIL     = 8;
	localparam int PHASE_ITEMS    = 290;
	localparam int MIN_FRAMES     = 30;
	localparam int REPORT_LIMIT   = 10;
	localparam int TIMEOUT_CYCLES = 1_000_000;

	// Indexes past the last window register; writes to them must be ignored.
	localparam logic [REG_IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_SPARE_B = 3'd7;

	typedef enum logic [1:0] {CLS_START, CLS_ZERO, CLS_ONE, CLS_BAD} tick_class_t;

	typedef struct packed {
		logic [TICK_W-1:0] dev_high;
		logic [TICK_W-1:0] dev_low;
		logic [TICK_W-1:0] key;
	} ir_frame_t;

	// Predicts decoded frames and checks the result beats against them.
	class frame_scoreboard;
		windows_t           win;
		int                 bits_seen;
		logic [FRAME_W-1:0] frame_shift;
		bit                 bad_bit;
		ir_frame_t          frames_due[$];
		int                 intervals_noted;
		int                 frames_expected;
		int                 frames_checked;
		int                 mismatches;

		function new();
			win = '{start_min: RST_START_MIN, start_max: RST_START_MAX,
				zero_min: RST_ZERO_MIN, zero_max: RST_ZERO_MAX,
				one_min: RST_ONE_MIN, one_max: RST_ONE_MAX};
			bits_seen = 0;
			frame_shift = '0;
			bad_bit = 1'b0;
			intervals_noted = 0;
			frames_expected = 0;
			frames_checked = 0;
			mismatches = 0;
		endfunction

		function void write_reg(logic [REG_IDX_W-1:0] idx, logic [TICK_W-1:0] d);
			case (idx)
				REG_START_MIN: win.start_min = d;
				REG_START_MAX: win.start_max = d;
				REG_ZERO_MIN:  win.zero_min = d;
				REG_ZERO_MAX:  win.zero_max = d;
				REG_ONE_MIN:   win.one_min = d;
				REG_ONE_MAX:   win.one_max = d;
				default: ;
			endcase
		endfunction

		function bit in_window(logic [TICK_W-1:0] v, logic [TICK_W-1:0] lo,
			logic [TICK_W-1:0] hi);
			return v > lo && v < hi;
		endfunction

		// The start window wins over the bit windows, and zero wins over one.
		function tick_class_t classify(logic [TICK_W-1:0] v);
			if (in_window(v, win.start_min, win.start_max)) return CLS_START;
			if (in_window(v, win.zero_min, win.zero_max)) return CLS_ZERO;
			if (in_window(v, win.one_min, win.one_max)) return CLS_ONE;
			return CLS_BAD;
		endfunction

		function bit reachable(tick_class_t c);
			for (int v = 0; v < 256; v++) begin
				if (classify(TICK_W'(v)) == c) return 1'b1;
			end
			return 1'b0;
		endfunction

		// One accepted interval beat: update the frame state and queue a frame
		// when the thirty-second bit completes a clean, consistent frame.
		function void note_interval(logic [TICK_W-1:0] ticks);
			tick_class_t cls;
			cls = classify(ticks);
			intervals_noted++;
			if (cls == CLS_START) begin
				bits_seen = 0;
				bad_bit = 1'b0;
				return;
			end
			if (cls == CLS_BAD) bad_bit = 1'b1;
			frame_shift = {cls == CLS_ONE, frame_shift[FRAME_W-1:1]};
			bits_seen++;
			if (bits_seen < FRAME_W) return;
			bits_seen = 0;
			if (bad_bit) begin
				bad_bit = 1'b0;
				return;
			end
			if ((frame_shift[23:16] | frame_shift[31:24]) != BYTE_ALL_ONES) return;
			frames_due.push_back('{dev_high: frame_shift[7:0], dev_low: frame_shift[15:8],
				key: frame_shift[23:16]});
			frames_expected++;
		endfunction

		function void check_result(logic [TICK_W-1:0] dh, logic [TICK_W-1:0] dl,
			logic [TICK_W-1:0] kc);
			ir_frame_t want;
			if (frames_due.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected result beat: device %02h%02h key %02h", dh, dl, kc);
				return;
			end
			want = frames_due.pop_front();
			frames_checked++;
			if (want.dev_high !== dh || want.dev_low !== dl || want.key !== kc) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("frame %0d mismatch: expected %02h/%02h/%02h, got %02h/%02h/%02h",
						frames_checked, want.dev_high, want.dev_low, want.key, dh, dl, kc);
			end
		endfunction

		function int pending();
			return frames_due.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [TICK_W-1:0]    interval_ticks;
	logic                 out_valid;
	logic                 out_ready;
	logic [TICK_W-1:0]    device_high;
	logic [TICK_W-1:0]    device_low;
	logic [TICK_W-1:0]    key_code;
	logic                 cfg_we;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [TICK_W-1:0]    cfg_data;

	frame_scoreboard sb;
	bit              calm;
	int              settings_run;

	ir_pulse_frame_decoder DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.interval_ticks(interval_ticks),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.device_high   (device_high),
		.device_low    (device_low),
		.key_code      (key_code),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Idle gap in cycles: mostly none or short, now and then a long one.
	function automatic int pick_gap(bit quiet);
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Random tick count of the wanted class under the current windows; falls
	// back to any value when no tick count has that class.
	function automatic logic [TICK_W-1:0] pick_tick(tick_class_t want);
		logic [TICK_W-1:0] lo;
		logic [TICK_W-1:0] hi;
		logic [TICK_W-1:0] v;
		case (want)
			CLS_START: begin
				lo = sb.win.start_min;
				hi = sb.win.start_max;
			end
			CLS_ZERO: begin
				lo = sb.win.zero_min;
				hi = sb.win.zero_max;
			end
			CLS_ONE: begin
				lo = sb.win.one_min;
				hi = sb.win.one_max;
			end
			default: begin
				lo = '0;
				hi = '0;
			end
		endcase
		for (int i = 0; i < 64; i++) begin
			if (want != CLS_BAD && hi > lo + 1)
				v = TICK_W'($urandom_range(lo + 1, hi - 1));
			else
				v = TICK_W'($urandom_range(0, 255));
			if (sb.classify(v) == want) return v;
		end
		for (int i = 0; i < 256; i++) begin
			v = TICK_W'($urandom_range(0, 255));
			if (sb.classify(v) == want) return v;
		end
		return TICK_W'($urandom_range(0, 255));
	endfunction

	// Offers one interval beat and waits until it is taken.
	task automatic send_interval(logic [TICK_W-1:0] v);
		int gap;
		gap = pick_gap(calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		interval_ticks <= v;
		do @(posedge clk); while (!in_ready);
		sb.note_interval(v);
	endtask

	// Stops sending and waits until every predicted frame has come out, then
	// lets the pipeline settle for beats that produce no frame.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.pending() > 0) @(posedge clk);
		repeat (DRAIN_TAIL) @(posedge clk);
	endtask

	// Writes all six window registers, then both spare indexes.
	task automatic load_windows(windows_t w);
		logic [REG_IDX_W-1:0] idx [8];
		logic [TICK_W-1:0]    val [8];
		idx = '{REG_START_MIN, REG_START_MAX, REG_ZERO_MIN, REG_ZERO_MAX,
			REG_ONE_MIN, REG_ONE_MAX, REG_SPARE_A, REG_SPARE_B};
		val = '{w.start_min, w.start_max, w.zero_min, w.zero_max, w.one_min, w.one_max,
			TICK_W'($urandom), TICK_W'($urandom)};
		for (int i = 0; i < 8; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			@(posedge clk);
			sb.write_reg(idx[i], val[i]);
		end
		cfg_we <= 1'b0;
		settings_run++;
	endtask

	// Hand-picked intervals under the reset windows: both tick extremes, the
	// exclusive edges of every window, bits without a start, and a start in
	// the middle of a frame.
	task automatic run_directed();
		logic [TICK_W-1:0] seq [$];
		seq = '{8'd0, 8'd255, 8'd6, 8'd10, 8'd14, 8'd18, 8'd97, 8'd5, 8'd11, 8'd12,
			8'd13, 8'd19, 8'd91, 8'd15, 8'd90, 8'd105, 8'd104, 8'd128, 8'd127};
		foreach (seq[i]) send_interval(seq[i]);
	endtask

	// One frame-shaped burst. Most are clean frames; the rest carry a failing
	// command check, a bad bit, a cut-off tail, no start, or plain noise.
	task automatic send_frame();
		logic [FRAME_W-1:0] word;
		int                 kind;
		int                 bad_pos;
		int                 cut;
		calm = ($urandom_range(0, 3) == 0);
		kind = $urandom_range(0, 99);
		if (kind >= 93) begin
			repeat ($urandom_range(1, 8)) send_interval(TICK_W'($urandom_range(0, 255)));
			return;
		end
		word = $urandom;
		if (kind < 60)
			word[31:24] = ~word[23:16];
		else if (kind < 67)
			word[31:24] = ~word[23:16] | TICK_W'($urandom);
		else if (kind >= 74)
			word[31:24] = ~word[23:16];
		bad_pos = (kind >= 74 && kind < 82) ? $urandom_range(0, FRAME_W - 1) : -1;
		cut = (kind >= 82 && kind < 88) ? $urandom_range(1, FRAME_W - 1) : FRAME_W;
		if (kind < 88) begin
			// Without a usable start window, pad the running frame to its end.
			if (sb.reachable(CLS_START))
				send_interval(pick_tick(CLS_START));
			else
				while (sb.bits_seen != 0)
					send_interval(pick_tick($urandom_range(0, 1) ? CLS_ONE : CLS_ZERO));
		end
		for (int i = 0; i < cut; i++)
			send_interval(pick_tick(i == bad_pos ? CLS_BAD :
				(word[i] ? CLS_ONE : CLS_ZERO)));
	endtask

	// Main stimulus.
	initial begin
		windows_t plan [5];
		int       target;
		arst_n = 1'b0;
		in_valid = 1'b0;
		interval_ticks = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		calm = 1'b0;
		settings_run = 1;
		sb = new();
		// Extremes: inverted start window, bit windows meeting at mid-range.
		plan[0] = '{start_min: 8'd255, start_max: 8'd0, zero_min: 8'd0, zero_max: 8'd128,
			one_min: 8'd127, one_max: 8'd255};
		// Start window overlapping zero, zero overlapping one.
		plan[1] = '{start_min: 8'd40, start_max: 8'd60, zero_min: 8'd50, zero_max: 8'd70,
			one_min: 8'd65, one_max: 8'd90};
		// Single-value windows.
		plan[2] = '{start_min: 8'd200, start_max: 8'd202, zero_min: 8'd0, zero_max: 8'd2,
			one_min: 8'd253, one_max: 8'd255};
		// Empty start window and overlapping bit windows.
		plan[3] = '{start_min: 8'd100, start_max: 8'd101, zero_min: 8'd20, zero_max: 8'd40,
			one_min: 8'd30, one_max: 8'd60};
		// One window covering all but both extremes, zero taking almost all of it.
		plan[4] = '{start_min: 8'd0, start_max: 8'd3, zero_min: 8'd3, zero_max: 8'd255,
			one_min: 8'd0, one_max: 8'd255};

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();

		// Reset windows, with a full pause halfway through.
		target = sb.intervals_noted + PHASE_ITEMS / 2;
		while (sb.intervals_noted < target) send_frame();
		wait_drained();
		target = sb.intervals_noted + PHASE_ITEMS / 2;
		while (sb.intervals_noted < target) send_frame();

		foreach (plan[p]) begin
			wait_drained();
			load_windows(plan[p]);
			target = sb.intervals_noted + PHASE_ITEMS;
			while (sb.intervals_noted < target) send_frame();
		end

		// Top up with frames under the reset windows until enough have decoded.
		wait_drained();
		load_windows('{start_min: RST_START_MIN, start_max: RST_START_MAX,
			zero_min: RST_ZERO_MIN, zero_max: RST_ZERO_MAX,
			one_min: RST_ONE_MIN, one_max: RST_ONE_MAX});
		while (sb.frames_expected < MIN_FRAMES) send_frame();
		wait_drained();

		$display("summary: %0d interval beats over %0d window settings, %0d frames checked",
			sb.intervals_noted, settings_run, sb.frames_checked);
		$display("summary: %0d mismatching or unexpected result beats", sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// Result side: ready runs of random length broken by random stalls.
	initial begin
		int run;
		int stall;
		out_ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
			out_ready <= 1'b1;
			repeat (run) @(posedge clk);
			stall = pick_gap(1'b0);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	// Check every result beat as it is taken.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(device_high, device_low, key_code);
	end

	// Watchdog.
	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("tb: failure");
		$finish;
	end

endmodule
